[design/tks_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants of the top-k selector.
// ----------------------------------------------------------------------------
package tks_pkg;

   localparam int unsigned ID_W   = 32;
   localparam int unsigned KEY_W  = 32;
   localparam int unsigned KC_W   = 7;
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;

   localparam logic [KEY_W-1:0] KEY_UNBOUNDED = '1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_KEEP_COUNT = 1'b0;

   localparam logic MODE_OFFER = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_RD,
      ST_CHK_CMP,
      ST_INS_RD,
      ST_INS_CMP,
      ST_FIN,
      ST_WORST_GET,
      ST_EMIT,
      ST_EMIT_EMPTY,
      ST_DRAIN_RD,
      ST_DRAIN_EMIT
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage
`default_nettype wire

[design/top_k_selector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_selector
// Keeps the keep_count best (id, key) items, lower key first, lower id on
// ties, in a sorted one-read one-write store; drains them best-first.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  req_      in         req_valid / req_stall      mode, cand_id, cand_key
//  rsp_      out        rsp_valid / rsp_stall      accepted .. last_entry
//  csr_      in/out     APB, pready tied high      keep_count at byte 0
//
//  Offer: a rejected item reads and compares the worst entry; a stored one
//  is shifted into place entry by entry through the one-read one-write store.
//  Drain: a read and a result per kept entry; an empty store gives one result.
//  One item at a time: req_stall is high while an item is in work.
//  Results sit in an output register; rsp_stall holds it and the sequencer.
//  Synchronous reset clears the count (store empty) and sets keep_count to 1.
// ----------------------------------------------------------------------------
module top_k_selector #(
   parameter int unsigned MAX_KEEP = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic                         req_mode,
   input  wire logic [tks_pkg::ID_W-1:0]     req_cand_id,
   input  wire logic [tks_pkg::KEY_W-1:0]    req_cand_key,

   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic                         rsp_accepted,
   output      logic                         rsp_store_full,
   output      logic [tks_pkg::KEY_W-1:0]    rsp_worst_key,
   output      logic                         rsp_entry_valid,
   output      logic [tks_pkg::ID_W-1:0]     rsp_entry_id,
   output      logic [tks_pkg::KEY_W-1:0]    rsp_entry_key,
   output      logic                         rsp_last_entry,

   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [tks_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [tks_pkg::CSR_DW-1:0]   csr_pwdata,
   output      logic [tks_pkg::CSR_DW-1:0]   csr_prdata,
   output      logic                         csr_pready
);

   localparam int unsigned CNT_W  = $clog2(MAX_KEEP + 1);
   localparam int unsigned ADDR_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   function automatic logic better(input tks_pkg::entry_type a,
                                   input tks_pkg::entry_type b);
      logic res;
      if (a.key != b.key) begin
         res = a.key < b.key;
      end else begin
         res = a.id < b.id;
      end
      return res;
   endfunction

   tks_pkg::state_type state_ff, state_in;

   logic [tks_pkg::KC_W-1:0] keep_count_ff, keep_count_in;
   logic [CNT_W-1:0]         total_ff, total_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   tks_pkg::entry_type       cand_ff, cand_in;
   logic                     acc_ff, acc_in;
   logic [tks_pkg::KEY_W-1:0] worst_ff, worst_in;
   logic [CNT_W-1:0]         keep_eff;

   tks_pkg::entry_type mem [MAX_KEEP];
   tks_pkg::entry_type rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   tks_pkg::entry_type mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_load;
   logic                      out_free;
   logic                      o_acc_ff, o_acc_in;
   logic                      o_full_ff, o_full_in;
   logic [tks_pkg::KEY_W-1:0] o_worst_ff, o_worst_in;
   logic                      o_ev_ff, o_ev_in;
   tks_pkg::entry_type        o_entry_ff, o_entry_in;
   logic                      o_last_ff, o_last_in;

   logic req_take;
   logic cfg_we;
   logic cand_better;
   logic is_full;
   logic drain_last;

   assign req_stall  = (state_ff != tks_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == tks_pkg::CSR_IDX_KEEP_COUNT);
   assign csr_prdata = (csr_paddr[2] == tks_pkg::CSR_IDX_KEEP_COUNT) ?
                       {{(tks_pkg::CSR_DW - tks_pkg::KC_W){1'b0}}, keep_count_ff} :
                       '0;

   always_comb begin
      if (keep_count_ff == '0) begin
         keep_eff = CNT_W'(1);
      end else if (32'(keep_count_ff) > 32'(MAX_KEEP)) begin
         keep_eff = CNT_W'(MAX_KEEP);
      end else begin
         keep_eff = CNT_W'(keep_count_ff);
      end
   end

   assign cand_better = better(cand_ff, rd_data_ff);
   assign is_full     = (total_ff >= keep_eff);
   assign drain_last  = (pos_ff == ADDR_W'(total_ff - CNT_W'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tks_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_mode == tks_pkg::MODE_DRAIN) begin
                  state_in = (total_ff == '0) ? tks_pkg::ST_EMIT_EMPTY
                                              : tks_pkg::ST_DRAIN_RD;
               end else begin
                  state_in = (total_ff < keep_eff) ? tks_pkg::ST_INS_RD
                                                   : tks_pkg::ST_CHK_RD;
               end
            end
         end
         tks_pkg::ST_CHK_RD:  state_in = tks_pkg::ST_CHK_CMP;
         tks_pkg::ST_CHK_CMP: begin
            state_in = cand_better ? tks_pkg::ST_INS_RD : tks_pkg::ST_EMIT;
         end
         tks_pkg::ST_INS_RD: begin
            state_in = (pos_ff == '0) ? tks_pkg::ST_FIN : tks_pkg::ST_INS_CMP;
         end
         tks_pkg::ST_INS_CMP: begin
            state_in = cand_better ? tks_pkg::ST_INS_RD : tks_pkg::ST_FIN;
         end
         tks_pkg::ST_FIN: begin
            state_in = is_full ? tks_pkg::ST_WORST_GET : tks_pkg::ST_EMIT;
         end
         tks_pkg::ST_WORST_GET: state_in = tks_pkg::ST_EMIT;
         tks_pkg::ST_EMIT, tks_pkg::ST_EMIT_EMPTY: begin
            if (out_free) begin
               state_in = tks_pkg::ST_IDLE;
            end
         end
         tks_pkg::ST_DRAIN_RD: state_in = tks_pkg::ST_DRAIN_EMIT;
         tks_pkg::ST_DRAIN_EMIT: begin
            if (out_free) begin
               state_in = drain_last ? tks_pkg::ST_IDLE : tks_pkg::ST_DRAIN_RD;
            end
         end
         default: state_in = tks_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      keep_count_in = keep_count_ff;
      total_in      = total_ff;
      pos_in        = pos_ff;
      cand_in       = cand_ff;
      acc_in        = acc_ff;
      worst_in      = worst_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = cand_ff;
      mem_raddr     = pos_ff;
      out_load      = 1'b0;
      o_acc_in      = acc_ff;
      o_full_in     = is_full;
      o_worst_in    = worst_ff;
      o_ev_in       = 1'b0;
      o_entry_in    = '0;
      o_last_in     = 1'b1;

      case (state_ff)
         tks_pkg::ST_IDLE: begin
            if (req_take) begin
               cand_in.id  = req_cand_id;
               cand_in.key = req_cand_key;
               acc_in      = 1'b0;
               pos_in      = (req_mode == tks_pkg::MODE_DRAIN) ? '0
                                                               : ADDR_W'(total_ff);
            end
         end
         tks_pkg::ST_CHK_RD: begin
            mem_raddr = ADDR_W'(total_ff - CNT_W'(1));
         end
         tks_pkg::ST_CHK_CMP: begin
            if (cand_better) begin
               total_in = total_ff - CNT_W'(1);
               pos_in   = ADDR_W'(total_ff - CNT_W'(1));
            end else begin
               worst_in = rd_data_ff.key;
            end
         end
         tks_pkg::ST_INS_RD: begin
            mem_raddr = pos_ff - ADDR_W'(1);
            if (pos_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = cand_ff;
               total_in  = total_ff + CNT_W'(1);
            end
         end
         tks_pkg::ST_INS_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            if (cand_better) begin
               mem_wdata = rd_data_ff;
               pos_in    = pos_ff - ADDR_W'(1);
            end else begin
               mem_wdata = cand_ff;
               total_in  = total_ff + CNT_W'(1);
            end
         end
         tks_pkg::ST_FIN: begin
            acc_in    = 1'b1;
            worst_in  = tks_pkg::KEY_UNBOUNDED;
            mem_raddr = ADDR_W'(total_ff - CNT_W'(1));
         end
         tks_pkg::ST_WORST_GET: begin
            worst_in = rd_data_ff.key;
         end
         tks_pkg::ST_EMIT: begin
            out_load = out_free;
         end
         tks_pkg::ST_EMIT_EMPTY: begin
            out_load   = out_free;
            o_acc_in   = 1'b0;
            o_full_in  = 1'b0;
            o_worst_in = tks_pkg::KEY_UNBOUNDED;
         end
         tks_pkg::ST_DRAIN_RD: begin
            mem_raddr = pos_ff;
         end
         tks_pkg::ST_DRAIN_EMIT: begin
            out_load   = out_free;
            o_acc_in   = 1'b0;
            o_full_in  = 1'b0;
            o_worst_in = tks_pkg::KEY_UNBOUNDED;
            o_ev_in    = 1'b1;
            o_entry_in = rd_data_ff;
            o_last_in  = drain_last;
            if (out_free) begin
               if (drain_last) begin
                  total_in = '0;
               end else begin
                  pos_in = pos_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
         end
      endcase

      if (cfg_we) begin
         keep_count_in = csr_pwdata[tks_pkg::KC_W-1:0];
         total_in      = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tks_pkg::ST_IDLE;
         keep_count_ff <= tks_pkg::KC_W'(1);
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keep_count_ff <= keep_count_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      cand_ff  <= cand_in;
      acc_ff   <= acc_in;
      worst_ff <= worst_in;
      if (out_load) begin
         o_acc_ff   <= o_acc_in;
         o_full_ff  <= o_full_in;
         o_worst_ff <= o_worst_in;
         o_ev_ff    <= o_ev_in;
         o_entry_ff <= o_entry_in;
         o_last_ff  <= o_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = o_acc_ff;
   assign rsp_store_full  = o_full_ff;
   assign rsp_worst_key   = o_worst_ff;
   assign rsp_entry_valid = o_ev_ff;
   assign rsp_entry_id    = o_entry_ff.id;
   assign rsp_entry_key   = o_entry_ff.key;
   assign rsp_last_entry  = o_last_ff;

endmodule
`default_nettype wire
